// ===== hw/rtl/asf_pkg.sv =====
`default_nettype none

package asf_pkg;

    // sequence capacity and the widths that follow from it
    localparam int MAX_VALUES = 64;
    localparam int IDX_W      = $clog2(MAX_VALUES);
    localparam int CNT_W      = $clog2(MAX_VALUES + 1);

    // run buffering: one member list bank per queued run
    localparam int NUM_BANKS  = 2;
    localparam int BANK_W     = $clog2(NUM_BANKS);
    localparam int ADDR_W     = IDX_W + BANK_W;
    localparam int RAM_DEPTH  = NUM_BANKS * MAX_VALUES;

    // field widths of the ports
    localparam int VALUE_W    = 32;
    localparam int TOL_W      = 31;
    localparam int INDEX_W    = 6;
    localparam int ACT_W      = 7;
    localparam int EQ_W       = 6;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(65);

    // summary of one finished sequence, handed from front to back
    typedef struct packed {
        logic [BANK_W-1:0]  bank;
        logic [VALUE_W-1:0] minimum;
        logic [CNT_W-1:0]   count;
        logic [IDX_W-1:0]   same;
        logic               ovf;
    } t_run;

    typedef struct packed {
        logic valid;
        t_run run;
    } t_run_push;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [INDEX_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

endpackage

`default_nettype wire

// ===== hw/rtl/active_set_finder.sv =====
// output: a value marked last reaches its first result through the run queue,
//   ram read and output register, then one result a cycle while i_ready is high
// throughput: one value a cycle while o_ready; one member list ram read a cycle
//   while i_ready; o_ready drops only while two finished runs wait to be emitted
// reset: synchronous active low; tolerance returns to 65, sequence state clears,
//   the member list ram is not cleared (entries are written before use)
`default_nettype none

module active_set_finder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [asf_pkg::TOL_W-1:0]    i_cfg_wdata,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [asf_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                         i_last,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [asf_pkg::INDEX_W-1:0]       o_index,
    output logic [asf_pkg::VALUE_W-1:0]       o_minimum,
    output logic [asf_pkg::ACT_W-1:0]         o_active_count,
    output logic [asf_pkg::EQ_W-1:0]          o_equal_count,
    output logic                              o_overflow,
    output logic                              o_last_out
);

    asf_pkg::t_run_push            w_push;
    asf_pkg::t_mem_wr              w_mem_wr;
    asf_pkg::t_mem_rd              w_mem_rd;
    asf_pkg::t_run                 w_head;
    logic                          w_q_full;
    logic                          w_q_nonempty;
    logic                          w_pop;
    logic [asf_pkg::INDEX_W-1:0]   w_rd_data;

    // front: takes values, tracks anchor and minimum, appends members
    asf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_last      (i_last),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_mem_wr    (w_mem_wr)
    );

    // finished runs between front and back
    asf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_full     (w_q_full),
        .o_nonempty (w_q_nonempty),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // member lists, one bank per queued run
    asf_ram #(
        .WIDTH (asf_pkg::INDEX_W),
        .DEPTH (asf_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_wr.en),
        .i_waddr (w_mem_wr.addr),
        .i_wdata (w_mem_wr.data),
        .i_re    (w_mem_rd.en),
        .i_raddr (w_mem_rd.addr),
        .o_rdata (w_rd_data)
    );

    // back: emits one result per member
    asf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nonempty     (w_q_nonempty),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_mem_rd       (w_mem_rd),
        .i_rd_data      (w_rd_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_index        (o_index),
        .o_minimum      (o_minimum),
        .o_active_count (o_active_count),
        .o_equal_count  (o_equal_count),
        .o_overflow     (o_overflow),
        .o_last_out     (o_last_out)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_active_count != '0)
                 && (o_active_count <= asf_pkg::ACT_W'(asf_pkg::MAX_VALUES)))
        else $error("active count out of range");
    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_out |=> o_valid)
        else $error("gap inside an emitted run");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !o_ready)
        else $error("input ready while both banks are in use");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown straight after reset");

endmodule

`default_nettype wire

// ===== hw/rtl/asf_ram.sv =====
`default_nettype none

module asf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port that holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/asf_front.sv =====
`default_nettype none

module asf_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [asf_pkg::TOL_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [asf_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                          i_last,
    input  wire logic                          i_q_full,
    output asf_pkg::t_run_push                 o_push,
    output asf_pkg::t_mem_wr                   o_mem_wr
);

    logic [asf_pkg::TOL_W-1:0]        r_tol;
    logic signed [asf_pkg::VALUE_W-1:0] r_anchor, n_anchor;
    logic signed [asf_pkg::VALUE_W-1:0] r_min, n_min;
    logic [asf_pkg::CNT_W-1:0]        r_count, n_count;
    logic [asf_pkg::IDX_W-1:0]        r_same, n_same;
    logic [asf_pkg::CNT_W-1:0]        r_item, n_item;
    logic                             r_ovf, n_ovf;
    logic [asf_pkg::BANK_W-1:0]       r_bank;

    logic                             accept;
    logic signed [asf_pkg::VALUE_W-1:0] val;
    logic signed [asf_pkg::VALUE_W+1:0] diff;
    logic [asf_pkg::VALUE_W:0]        mag;
    logic [asf_pkg::VALUE_W:0]        tol_ext;
    logic                             below, restart, joins, first, full;

    assign accept  = i_valid && !i_q_full;
    assign o_ready = !i_q_full;
    assign val     = $signed(i_value);

    // exact signed difference to the anchor in 34 bits, its magnitude in 33 bits
    assign diff    = {{2{val[asf_pkg::VALUE_W-1]}}, val}
                   - {{2{r_anchor[asf_pkg::VALUE_W-1]}}, r_anchor};
    assign mag     = diff[asf_pkg::VALUE_W+1] ? (asf_pkg::VALUE_W+1)'(-diff)
                                              : diff[asf_pkg::VALUE_W:0];
    assign tol_ext = {2'b00, r_tol};
    assign below   = val < r_anchor;
    assign restart = below && (mag > tol_ext);
    assign joins   = !restart && (mag < tol_ext);
    assign first   = r_item == '0;
    assign full    = r_item >= asf_pkg::CNT_W'(asf_pkg::MAX_VALUES);

    // classify the value and work out the next sequence state
    always_comb begin
        n_anchor = r_anchor;
        n_min    = r_min;
        n_count  = r_count;
        n_same   = r_same;
        n_item   = r_item;
        n_ovf    = r_ovf;
        o_mem_wr.en   = 1'b0;
        o_mem_wr.addr = {r_bank, asf_pkg::IDX_W'(0)};
        o_mem_wr.data = asf_pkg::INDEX_W'(r_item);
        if (accept) begin
            if (full) begin
                n_ovf = 1'b1;
            end else if (first) begin
                n_anchor    = val;
                n_min       = val;
                n_count     = asf_pkg::CNT_W'(1);
                n_same      = '0;
                n_item      = asf_pkg::CNT_W'(1);
                o_mem_wr.en = 1'b1;
            end else begin
                if (val < r_min) begin
                    n_min = val;
                end
                if (restart) begin
                    n_anchor    = val;
                    n_count     = asf_pkg::CNT_W'(1);
                    n_same      = '0;
                    o_mem_wr.en = 1'b1;
                end else if (joins) begin
                    n_count       = asf_pkg::CNT_W'(r_count + 1'b1);
                    o_mem_wr.en   = 1'b1;
                    o_mem_wr.addr = {r_bank, r_count[asf_pkg::IDX_W-1:0]};
                    if (mag == '0) begin
                        n_same = asf_pkg::IDX_W'(r_same + 1'b1);
                    end
                end
                n_item = asf_pkg::CNT_W'(r_item + 1'b1);
            end
        end
    end

    // hand the finished sequence to the queue on the last value
    always_comb begin
        o_push.valid       = accept && i_last;
        o_push.run.bank    = r_bank;
        o_push.run.minimum = n_min;
        o_push.run.count   = n_count;
        o_push.run.same    = n_same;
        o_push.run.ovf     = n_ovf;
    end

    // sequence state, cleared after a last value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= asf_pkg::TOL_RESET;
            r_anchor <= '0;
            r_min    <= '0;
            r_count  <= '0;
            r_same   <= '0;
            r_item   <= '0;
            r_ovf    <= 1'b0;
            r_bank   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (accept && i_last) begin
                r_anchor <= '0;
                r_min    <= '0;
                r_count  <= '0;
                r_same   <= '0;
                r_item   <= '0;
                r_ovf    <= 1'b0;
                r_bank   <= (r_bank == asf_pkg::BANK_W'(asf_pkg::NUM_BANKS - 1))
                          ? '0 : asf_pkg::BANK_W'(r_bank + 1'b1);
            end else if (accept) begin
                r_anchor <= n_anchor;
                r_min    <= n_min;
                r_count  <= n_count;
                r_same   <= n_same;
                r_item   <= n_item;
                r_ovf    <= n_ovf;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/asf_queue.sv =====
`default_nettype none

module asf_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire asf_pkg::t_run_push i_push,
    output logic                    o_full,
    output logic                    o_nonempty,
    output asf_pkg::t_run           o_head,
    input  wire logic               i_pop
);

    localparam int PTR_W = $clog2(asf_pkg::NUM_BANKS);
    localparam int QC_W  = $clog2(asf_pkg::NUM_BANKS + 1);

    asf_pkg::t_run     r_entry [asf_pkg::NUM_BANKS];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]   r_cnt;

    assign o_full     = r_cnt == QC_W'(asf_pkg::NUM_BANKS);
    assign o_nonempty = r_cnt != '0;
    assign o_head     = r_entry[r_rd_ptr];

    // run summaries wait here until the back end drains them
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_entry[r_wr_ptr] <= i_push.run;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(asf_pkg::NUM_BANKS - 1))
                          ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(asf_pkg::NUM_BANKS - 1))
                          ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push.valid && !i_pop) begin
                r_cnt <= QC_W'(r_cnt + 1'b1);
            end else if (!i_push.valid && i_pop) begin
                r_cnt <= QC_W'(r_cnt - 1'b1);
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.valid || i_pop)
        else $error("run queue pushed while full");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("run queue popped while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QC_W'(asf_pkg::NUM_BANKS))
        else $error("run queue fill level out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/asf_back.sv =====
`default_nettype none

module asf_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_nonempty,
    input  wire asf_pkg::t_run                i_head,
    output logic                              o_pop,
    output asf_pkg::t_mem_rd                  o_mem_rd,
    input  wire logic [asf_pkg::INDEX_W-1:0]  i_rd_data,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [asf_pkg::INDEX_W-1:0]       o_index,
    output logic [asf_pkg::VALUE_W-1:0]       o_minimum,
    output logic [asf_pkg::ACT_W-1:0]         o_active_count,
    output logic [asf_pkg::EQ_W-1:0]          o_equal_count,
    output logic                              o_overflow,
    output logic                              o_last_out
);

    logic [asf_pkg::CNT_W-1:0]   r_k;
    logic                        r_pend;
    logic [asf_pkg::VALUE_W-1:0] r_p_min;
    logic [asf_pkg::CNT_W-1:0]   r_p_cnt;
    logic [asf_pkg::IDX_W-1:0]   r_p_same;
    logic                        r_p_ovf;
    logic                        r_p_last;

    logic                        r_o_valid;
    logic [asf_pkg::INDEX_W-1:0] r_o_index;
    logic [asf_pkg::VALUE_W-1:0] r_o_min;
    logic [asf_pkg::CNT_W-1:0]   r_o_cnt;
    logic [asf_pkg::IDX_W-1:0]   r_o_same;
    logic                        r_o_ovf;
    logic                        r_o_last;

    logic move, issue, last_k;

    // read stage feeds the output register whenever it is free or taken
    assign move   = r_pend && (!r_o_valid || i_ready);
    assign issue  = i_nonempty && (!r_pend || move);
    assign last_k = asf_pkg::CNT_W'(r_k + 1'b1) == i_head.count;
    assign o_pop  = issue && last_k;

    assign o_mem_rd.en   = issue;
    assign o_mem_rd.addr = {i_head.bank, r_k[asf_pkg::IDX_W-1:0]};

    assign o_valid        = r_o_valid;
    assign o_index        = r_o_index;
    assign o_minimum      = r_o_min;
    assign o_active_count = asf_pkg::ACT_W'(r_o_cnt);
    assign o_equal_count  = asf_pkg::EQ_W'(r_o_same);
    assign o_overflow     = r_o_ovf;
    assign o_last_out     = r_o_last;

    // walk the member list and register each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_k <= last_k ? '0 : asf_pkg::CNT_W'(r_k + 1'b1);
            end
            if (issue) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // run fields travel with each read
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p_min  <= i_head.minimum;
            r_p_cnt  <= i_head.count;
            r_p_same <= i_head.same;
            r_p_ovf  <= i_head.ovf;
            r_p_last <= last_k;
        end
        if (move) begin
            r_o_index <= i_rd_data;
            r_o_min   <= r_p_min;
            r_o_cnt   <= r_p_cnt;
            r_o_same  <= r_p_same;
            r_o_ovf   <= r_p_ovf;
            r_o_last  <= r_p_last;
        end
    end

endmodule

`default_nettype wire
